// ===== design/imr_pkg.sv =====
`default_nettype none

package imr_pkg;

  localparam int IMR_ROWS  = 16;
  localparam int IMR_INNER = 16;
  localparam int IMR_COLS  = 16;

  localparam int KIND_W  = 2;
  localparam int INDEX_W = 4;
  localparam int DATA_W  = 32;

  localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

endpackage

`default_nettype wire

// ===== design/integer_matrix_multiply_rows_core.sv =====
`default_nettype none

// Dense integer matrix multiply-accumulate. Load transfers write one element of A or B
// and leave in_ready high. A compute transfer for row i adds A[i][:] * B[:][j] into
// C[i][j] for every column j and returns the updated entries in column order, with last
// on column COLS-1. Sums wrap modulo 2^32. A compute transfer holds in_ready low until
// its final column sum is registered, and longer while a column's sum waits on out_ready.
// The busy time is set by the single multiply-accumulate unit fed by one read port on each
// of the A and B memories. C clears to zero at reset through one flag per row, so no
// clearing pass is needed. Out-of-range indexes and kind 3 are dropped without results.
module integer_matrix_multiply_rows_core
  import imr_pkg::*;
#(
  parameter int ROWS  = IMR_ROWS,
  parameter int INNER = IMR_INNER,
  parameter int COLS  = IMR_COLS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [KIND_W-1:0]         kind,
  input  wire logic [INDEX_W-1:0]        row_index,
  input  wire logic [INDEX_W-1:0]        inner_index,
  input  wire logic [INDEX_W-1:0]        col_index,
  input  wire logic signed [DATA_W-1:0]  element,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [INDEX_W-1:0]             out_col,
  output logic signed [DATA_W-1:0]       out_value,
  output logic                           last
);

  localparam int AD  = ROWS * INNER;
  localparam int BD  = INNER * COLS;
  localparam int CD  = ROWS * COLS;
  localparam int AAW = (AD > 1) ? $clog2(AD) : 1;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
  localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KW  = (INNER > 1) ? $clog2(INNER) : 1;
  localparam int JW  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(INNER - 1);
  localparam logic [JW-1:0] J_LAST = JW'(COLS - 1);

  logic [DATA_W-1:0] a_mem [AD];
  logic [DATA_W-1:0] b_mem [BD];
  logic [DATA_W-1:0] c_mem [CD];

  logic [ROWS-1:0]   row_valid;
  logic              iss_act;
  logic [KW-1:0]     iss_k;
  logic [JW-1:0]     iss_j;
  logic [RW-1:0]     row_r;
  logic              clr_r;

  logic              s1_v, s1_first, s1_klast, s1_jl;
  logic [JW-1:0]     s1_j;
  logic [DATA_W-1:0] a_rd, b_rd, c_rd;

  logic              s2_v, s2_first, s2_klast, s2_jl;
  logic [JW-1:0]     s2_j;
  logic [DATA_W-1:0] prod, s2_c, acc;

  logic              busy, in_xfer, adv;
  logic              row_ok, inner_ok, col_ok;
  logic [RW-1:0]     in_row;
  logic [KW-1:0]     in_k;
  logic [JW-1:0]     in_j;
  logic [AAW-1:0]    a_waddr, a_raddr;
  logic [BAW-1:0]    b_waddr, b_raddr;
  logic [CAW-1:0]    c_waddr, c_raddr;
  logic [DATA_W-1:0] acc_sum;
  logic              col_done;

  assign busy     = iss_act | s1_v | s2_v;
  assign in_ready = !busy;
  assign in_xfer  = in_valid && in_ready;
  assign col_done = s2_v && s2_klast;
  assign adv      = !(col_done && out_valid && !out_ready);

  assign row_ok   = {28'd0, row_index} < 32'(ROWS);
  assign inner_ok = {28'd0, inner_index} < 32'(INNER);
  assign col_ok   = {28'd0, col_index} < 32'(COLS);
  assign in_row   = RW'(row_index);
  assign in_k     = KW'(inner_index);
  assign in_j     = JW'(col_index);

  assign a_waddr = AAW'(32'(in_row) * INNER + 32'(in_k));
  assign b_waddr = BAW'(32'(in_k) * COLS + 32'(in_j));
  assign a_raddr = AAW'(32'(row_r) * INNER + 32'(iss_k));
  assign b_raddr = BAW'(32'(iss_k) * COLS + 32'(iss_j));
  assign c_raddr = CAW'(32'(row_r) * COLS + 32'(iss_j));
  assign c_waddr = CAW'(32'(row_r) * COLS + 32'(s2_j));

  assign acc_sum = (s2_first ? s2_c : acc) + prod;

  always_ff @(posedge clk) begin
    if (in_xfer && kind == KIND_LOAD_A && row_ok && inner_ok) begin
      a_mem[a_waddr] <= element;
    end
    if (adv) begin
      a_rd <= a_mem[a_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && kind == KIND_LOAD_B && inner_ok && col_ok) begin
      b_mem[b_waddr] <= element;
    end
    if (adv) begin
      b_rd <= b_mem[b_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && col_done) begin
      c_mem[c_waddr] <= acc_sum;
    end
    if (adv) begin
      c_rd <= c_mem[c_raddr];
    end
  end

  // issue stage
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_act   <= 1'b0;
      row_valid <= '0;
    end else if (in_xfer) begin
      if (kind == KIND_COMPUTE && row_ok) begin
        iss_act           <= 1'b1;
        row_valid[in_row] <= 1'b1;
      end
    end else if (adv && iss_act && iss_k == K_LAST && iss_j == J_LAST) begin
      iss_act <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      iss_k <= '0;
      iss_j <= '0;
      row_r <= in_row;
      clr_r <= !row_valid[in_row];
    end else if (adv && iss_act) begin
      if (iss_k == K_LAST) begin
        iss_k <= '0;
        iss_j <= iss_j + 1'b1;
      end else begin
        iss_k <= iss_k + 1'b1;
      end
    end
  end

  // read and multiply stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (adv) begin
      s1_v <= iss_act;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first <= iss_k == '0;
      s1_klast <= iss_k == K_LAST;
      s1_j     <= iss_j;
      s1_jl    <= iss_j == J_LAST;
      s2_first <= s1_first;
      s2_klast <= s1_klast;
      s2_j     <= s1_j;
      s2_jl    <= s1_jl;
      prod     <= a_rd * b_rd;
      s2_c     <= clr_r ? '0 : c_rd;
      if (s2_v) begin
        acc <= acc_sum;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && col_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && col_done) begin
      out_col   <= INDEX_W'(s2_j);
      out_value <= acc_sum;
      last      <= s2_jl;
    end
  end

`ifndef SYNTH
  a_issue_feeds_read : assert property (@(posedge clk) disable iff (rst)
    adv |=> s1_v == $past(iss_act))
    else $error("read stage lost track of issue stage");

  a_compute_starts : assert property (@(posedge clk) disable iff (rst)
    in_xfer && kind == KIND_COMPUTE && row_ok |=> iss_act && row_valid[row_r])
    else $error("compute transfer did not start a row");

  a_last_column : assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> out_col == INDEX_W'(COLS - 1))
    else $error("last flag on a column other than the final one");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_col))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
